FILE: rtl/sdac_pkg.sv
// Shared types, constants and helpers for the sensor deadband alarm classifier.
`default_nettype none
package sdac_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PCT_W           = 7;
  localparam int IDX_W           = 3;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  typedef enum logic [1:0] {
    LVL_OK      = 2'd0,
    LVL_WARN    = 2'd1,
    LVL_ALARM   = 2'd2,
    LVL_INVALID = 2'd3
  } level_e;

  typedef enum logic [1:0] {
    FLT_NONE     = 2'd0,
    FLT_QUALITY  = 2'd1,
    FLT_TYPE     = 2'd2,
    FLT_BAD_NUM  = 2'd3
  } fault_e;

  typedef enum logic [IDX_W-1:0] {
    REG_DEADBAND   = 3'd0,
    REG_WARN_LOW   = 3'd1,
    REG_WARN_HIGH  = 3'd2,
    REG_ALARM_LOW  = 3'd3,
    REG_ALARM_HIGH = 3'd4,
    REG_HYST_PCT   = 3'd5,
    REG_STRICT     = 3'd6,
    REG_ANALOG     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic strict_policy;
    logic device_is_analog;
  } ctrl_t;

  // APB data width: 64 once a value no longer fits a 32 bit word
  function automatic int pdata_w(input int vw);
    return (vw > 32) ? 64 : 32;
  endfunction

  // byte address bits below the register index
  function automatic int pstride_log(input int vw);
    return (vw > 32) ? 3 : 2;
  endfunction

  function automatic int paddr_w(input int vw);
    return pstride_log(vw) + IDX_W;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sdac_if.sv
// Valid/ready channel interfaces for samples and classification results.
`default_nettype none
interface sdac_smp_if #(
  parameter int VALUE_WIDTH = sdac_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] sample;
  logic                   sample_quality_ok;
  logic                   sample_not_finite;

  modport source (output valid, sample, sample_quality_ok, sample_not_finite, input ready);
  modport sink   (input valid, sample, sample_quality_ok, sample_not_finite, output ready);
endinterface

interface sdac_res_if #(
  parameter int VALUE_WIDTH = sdac_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             level_status;
  logic [1:0]             fault_code;
  logic                   quality_flag;
  logic [VALUE_WIDTH-1:0] held_value;
  logic                   held_valid;
  logic                   sample_taken;

  modport source (output valid, level_status, fault_code, quality_flag, held_value,
                  held_valid, sample_taken, input ready);
  modport sink   (input valid, level_status, fault_code, quality_flag, held_value,
                  held_valid, sample_taken, output ready);
endinterface
`default_nettype wire

FILE: rtl/sensor_deadband_alarm_classifier_core.sv
// Top level: sample register, classifier state, result register and APB port.
//
//   channel | kind         | direction | payload
//   smp_i   | valid/ready  | in        | sample, sample_quality_ok, sample_not_finite
//   res_o   | valid/ready  | out       | level, fault, quality, held value/valid, taken
//   APB     | psel/penable | in/out    | eight config registers, 4 B (8 B if wide) apart
//
// One request per cycle while results are taken; each passes the sample register, then the result register.
// The sample register feeds the check/classify logic, whose outcome loads the
// state and the result register at the same edge, so back-to-back samples see
// up-to-date state. The hysteresis product is registered in the cycle after a
// config write. Reset (async, low) clears state; a stalled result holds the
// sample stage, and a new request is still taken whenever the result moves.
`default_nettype none
module sensor_deadband_alarm_classifier_core #(
  parameter int VALUE_WIDTH = sdac_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  sdac_smp_if.sink                                       smp_i,
  sdac_res_if.source                                     res_o,
  input  wire logic                                      psel,
  input  wire logic                                      penable,
  input  wire logic                                      pwrite,
  input  wire logic [sdac_pkg::paddr_w(VALUE_WIDTH)-1:0] paddr,
  input  wire logic [sdac_pkg::pdata_w(VALUE_WIDTH)-1:0] pwdata,
  output logic      [sdac_pkg::pdata_w(VALUE_WIDTH)-1:0] prdata,
  output logic                                           pready
);
  localparam int W  = VALUE_WIDTH;
  localparam int PW = sdac_pkg::PCT_W;

  // config
  logic [W-2:0]    deadband;
  logic [W-1:0]    warn_lo, warn_hi, alm_lo, alm_hi;
  logic [W+PW-1:0] hyst_prod;
  sdac_pkg::ctrl_t ctrl;

  // sample stage
  logic         s1_valid_q;
  logic [W-1:0] s1_sample_q;
  logic         s1_qok_q, s1_nf_q;

  // classifier state
  sdac_pkg::level_e level_q, level_d;
  sdac_pkg::fault_e fault_q, fault_d;
  logic             quality_q, quality_d;
  logic [W-1:0]     held_value_q, held_value_d;
  logic             held_valid_q, held_valid_d;
  logic             taken_d;

  // result stage
  logic         out_valid_q;
  logic [1:0]   out_level_q, out_fault_q;
  logic         out_quality_q, out_held_valid_q, out_taken_q;
  logic [W-1:0] out_held_value_q;

  logic advance;

  sdac_cfg #(.VALUE_WIDTH(W)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .deadband_o  (deadband),
    .warn_lo_o   (warn_lo),
    .warn_hi_o   (warn_hi),
    .alm_lo_o    (alm_lo),
    .alm_hi_o    (alm_hi),
    .hyst_prod_o (hyst_prod),
    .ctrl_o      (ctrl)
  );

  sdac_eval #(.VALUE_WIDTH(W)) u_eval (
    .sample_i     (s1_sample_q),
    .quality_ok_i (s1_qok_q),
    .not_finite_i (s1_nf_q),
    .held_value_i (held_value_q),
    .held_valid_i (held_valid_q),
    .level_i      (level_q),
    .fault_i      (fault_q),
    .quality_i    (quality_q),
    .deadband_i   (deadband),
    .warn_lo_i    (warn_lo),
    .warn_hi_i    (warn_hi),
    .alm_lo_i     (alm_lo),
    .alm_hi_i     (alm_hi),
    .hyst_prod_i  (hyst_prod),
    .ctrl_i       (ctrl),
    .level_o      (level_d),
    .fault_o      (fault_d),
    .quality_o    (quality_d),
    .held_value_o (held_value_d),
    .held_valid_o (held_valid_d),
    .taken_o      (taken_d)
  );

  // sample stage moves whenever the result register is free or draining
  assign advance     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign smp_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (smp_i.ready) begin
      s1_valid_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      s1_sample_q <= smp_i.sample;
      s1_qok_q    <= smp_i.sample_quality_ok;
      s1_nf_q     <= smp_i.sample_not_finite;
    end
  end

  // state commits only when the request's result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= sdac_pkg::LVL_OK;
      fault_q      <= sdac_pkg::FLT_NONE;
      quality_q    <= 1'b1;
      held_value_q <= '0;
      held_valid_q <= 1'b0;
    end else if (advance) begin
      level_q      <= level_d;
      fault_q      <= fault_d;
      quality_q    <= quality_d;
      held_value_q <= held_value_d;
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_level_q      <= level_d;
      out_fault_q      <= fault_d;
      out_quality_q    <= quality_d;
      out_held_value_q <= held_value_d;
      out_held_valid_q <= held_valid_d;
      out_taken_q      <= taken_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.level_status = out_level_q;
  assign res_o.fault_code   = out_fault_q;
  assign res_o.quality_flag = out_quality_q;
  assign res_o.held_value   = out_held_value_q;
  assign res_o.held_valid   = out_held_valid_q;
  assign res_o.sample_taken = out_taken_q;

`ifndef SYNTHESIS
  // any stored fault goes with an invalid level
  a_fault_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != sdac_pkg::FLT_NONE) |-> (level_q == sdac_pkg::LVL_INVALID))
    else $error("fault stored without invalid level");

  // held value only moves on a taken sample
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && taken_d) |=> $stable(held_value_q))
    else $error("held value changed without a taken sample");

  // a taken sample clears the fault and marks the held value valid
  a_taken_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_taken_q) |->
      (out_fault_q == sdac_pkg::FLT_NONE) && out_held_valid_q && out_quality_q)
    else $error("taken sample with fault or without held value");
`endif

endmodule
`default_nettype wire

FILE: rtl/sdac_cfg.sv
// APB register file and precomputed hysteresis product.
`default_nettype none
module sdac_cfg #(
  parameter int VALUE_WIDTH = sdac_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        psel,
  input  wire logic                                        penable,
  input  wire logic                                        pwrite,
  input  wire logic [sdac_pkg::paddr_w(VALUE_WIDTH)-1:0]   paddr,
  input  wire logic [sdac_pkg::pdata_w(VALUE_WIDTH)-1:0]   pwdata,
  output logic      [sdac_pkg::pdata_w(VALUE_WIDTH)-1:0]   prdata,
  output logic                                             pready,
  output logic      [VALUE_WIDTH-2:0]                      deadband_o,
  output logic      [VALUE_WIDTH-1:0]                      warn_lo_o,
  output logic      [VALUE_WIDTH-1:0]                      warn_hi_o,
  output logic      [VALUE_WIDTH-1:0]                      alm_lo_o,
  output logic      [VALUE_WIDTH-1:0]                      alm_hi_o,
  output logic      [VALUE_WIDTH+sdac_pkg::PCT_W-1:0]      hyst_prod_o,
  output sdac_pkg::ctrl_t                                  ctrl_o
);
  localparam int W      = VALUE_WIDTH;
  localparam int DW     = sdac_pkg::pdata_w(VALUE_WIDTH);
  localparam int AW     = sdac_pkg::paddr_w(VALUE_WIDTH);
  localparam int PW     = sdac_pkg::PCT_W;
  localparam int SL     = sdac_pkg::pstride_log(VALUE_WIDTH);

  logic [W-2:0]  deadband_q;
  logic [W-1:0]  warn_lo_q, warn_hi_q, alm_lo_q, alm_hi_q;
  logic [PW-1:0] pct_q;
  logic          strict_q, analog_q;
  logic [W+PW-1:0] hyst_prod_d, hyst_prod_q;

  sdac_pkg::reg_idx_e idx;
  logic               wr_en;
  logic signed [W:0]  span_diff;
  logic [W:0]         span_abs;
  logic [PW-1:0]      pct_eff;

  assign idx    = sdac_pkg::reg_idx_e'(paddr[AW-1:SL]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= '0;
      warn_lo_q  <= '0;
      warn_hi_q  <= '0;
      alm_lo_q   <= '0;
      alm_hi_q   <= '0;
      pct_q      <= '0;
      strict_q   <= 1'b1;
      analog_q   <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        sdac_pkg::REG_DEADBAND:   deadband_q <= pwdata[W-2:0];
        sdac_pkg::REG_WARN_LOW:   warn_lo_q  <= pwdata[W-1:0];
        sdac_pkg::REG_WARN_HIGH:  warn_hi_q  <= pwdata[W-1:0];
        sdac_pkg::REG_ALARM_LOW:  alm_lo_q   <= pwdata[W-1:0];
        sdac_pkg::REG_ALARM_HIGH: alm_hi_q   <= pwdata[W-1:0];
        sdac_pkg::REG_HYST_PCT:   pct_q      <= pwdata[PW-1:0];
        sdac_pkg::REG_STRICT:     strict_q   <= pwdata[0];
        sdac_pkg::REG_ANALOG:     analog_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sdac_pkg::REG_DEADBAND:   prdata = DW'(deadband_q);
      sdac_pkg::REG_WARN_LOW:   prdata = DW'(warn_lo_q);
      sdac_pkg::REG_WARN_HIGH:  prdata = DW'(warn_hi_q);
      sdac_pkg::REG_ALARM_LOW:  prdata = DW'(alm_lo_q);
      sdac_pkg::REG_ALARM_HIGH: prdata = DW'(alm_hi_q);
      sdac_pkg::REG_HYST_PCT:   prdata = DW'(pct_q);
      sdac_pkg::REG_STRICT:     prdata = DW'(strict_q);
      sdac_pkg::REG_ANALOG:     prdata = DW'(analog_q);
      default:                  prdata = '0;
    endcase
  end

  // pct * |warn_hi - warn_lo|; compared later against 100 * distance
  always_comb begin
    span_diff   = $signed({warn_hi_q[W-1], warn_hi_q}) -
                  $signed({warn_lo_q[W-1], warn_lo_q});
    span_abs    = span_diff[W] ? $unsigned(-span_diff) : $unsigned(span_diff);
    pct_eff     = (pct_q > sdac_pkg::PCT_MAX) ? sdac_pkg::PCT_MAX : pct_q;
    hyst_prod_d = (W+PW)'(span_abs[W-1:0]) * (W+PW)'(pct_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_prod_q <= '0;
    end else begin
      hyst_prod_q <= hyst_prod_d;
    end
  end

  assign deadband_o  = deadband_q;
  assign warn_lo_o   = warn_lo_q;
  assign warn_hi_o   = warn_hi_q;
  assign alm_lo_o    = alm_lo_q;
  assign alm_hi_o    = alm_hi_q;
  assign hyst_prod_o = hyst_prod_q;
  assign ctrl_o      = '{strict_policy: strict_q, device_is_analog: analog_q};

endmodule
`default_nettype wire

FILE: rtl/sdac_eval.sv
// Per-sample fault checks, deadband filter and level classification.
`default_nettype none
module sdac_eval #(
  parameter int VALUE_WIDTH = sdac_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic [VALUE_WIDTH-1:0]                 sample_i,
  input  wire logic                                   quality_ok_i,
  input  wire logic                                   not_finite_i,
  input  wire logic [VALUE_WIDTH-1:0]                 held_value_i,
  input  wire logic                                   held_valid_i,
  input  wire sdac_pkg::level_e                       level_i,
  input  wire sdac_pkg::fault_e                       fault_i,
  input  wire logic                                   quality_i,
  input  wire logic [VALUE_WIDTH-2:0]                 deadband_i,
  input  wire logic [VALUE_WIDTH-1:0]                 warn_lo_i,
  input  wire logic [VALUE_WIDTH-1:0]                 warn_hi_i,
  input  wire logic [VALUE_WIDTH-1:0]                 alm_lo_i,
  input  wire logic [VALUE_WIDTH-1:0]                 alm_hi_i,
  input  wire logic [VALUE_WIDTH+sdac_pkg::PCT_W-1:0] hyst_prod_i,
  input  wire sdac_pkg::ctrl_t                        ctrl_i,
  output sdac_pkg::level_e                            level_o,
  output sdac_pkg::fault_e                            fault_o,
  output logic                                        quality_o,
  output logic      [VALUE_WIDTH-1:0]                 held_value_o,
  output logic                                        held_valid_o,
  output logic                                        taken_o
);
  localparam int W  = VALUE_WIDTH;
  localparam int PW = sdac_pkg::PCT_W;

  // a - b > floor(P / 100)  <=>  100 * (a - b) > P, exact for integers
  function automatic logic beyond(input logic [W-1:0] a, input logic [W-1:0] b,
                                  input logic [W+PW-1:0] p);
    logic signed [W:0]    d;
    logic signed [W+PW:0] dx;
    logic signed [W+PW:0] m;
    d  = $signed({a[W-1], a}) - $signed({b[W-1], b});
    dx = (W+PW+1)'(d);
    m  = (dx <<< 6) + (dx <<< 5) + (dx <<< 2);
    return m > $signed({1'b0, p});
  endfunction

  logic signed [W-1:0] s, wl, wh, al, ah;
  logic                in_alarm, in_warn;
  sdac_pkg::level_e    plain_lvl, class_lvl;
  logic signed [W:0]   db_diff;
  logic [W:0]          db_abs;
  logic                drop;

  assign s  = $signed(sample_i);
  assign wl = $signed(warn_lo_i);
  assign wh = $signed(warn_hi_i);
  assign al = $signed(alm_lo_i);
  assign ah = $signed(alm_hi_i);

  always_comb begin
    in_alarm  = (s <= al) || (s >= ah);
    in_warn   = (s <= wl) || (s >= wh);
    plain_lvl = in_warn ? sdac_pkg::LVL_WARN : sdac_pkg::LVL_OK;
    if (in_alarm) begin
      class_lvl = sdac_pkg::LVL_ALARM;
    end else if (level_i == sdac_pkg::LVL_ALARM) begin
      // stay in alarm until clear of both alarm limits by the band
      if (!beyond(alm_hi_i, sample_i, hyst_prod_i) ||
          !beyond(sample_i, alm_lo_i, hyst_prod_i)) begin
        class_lvl = sdac_pkg::LVL_ALARM;
      end else begin
        class_lvl = plain_lvl;
      end
    end else if (level_i == sdac_pkg::LVL_WARN) begin
      if (beyond(sample_i, warn_lo_i, hyst_prod_i) &&
          beyond(warn_hi_i, sample_i, hyst_prod_i)) begin
        class_lvl = sdac_pkg::LVL_OK;
      end else begin
        class_lvl = sdac_pkg::LVL_WARN;
      end
    end else begin
      class_lvl = plain_lvl;
    end
  end

  always_comb begin
    db_diff = $signed({sample_i[W-1], sample_i}) - $signed({held_value_i[W-1], held_value_i});
    db_abs  = db_diff[W] ? $unsigned(-db_diff) : $unsigned(db_diff);
    drop    = held_valid_i && (deadband_i != '0) && (db_abs < (W+1)'(deadband_i));
  end

  always_comb begin
    level_o      = level_i;
    fault_o      = fault_i;
    quality_o    = quality_i;
    held_value_o = held_value_i;
    held_valid_o = held_valid_i;
    taken_o      = 1'b0;
    if (!quality_ok_i) begin
      quality_o = 1'b0;
      level_o   = sdac_pkg::LVL_INVALID;
      fault_o   = sdac_pkg::FLT_QUALITY;
    end else if (!ctrl_i.device_is_analog) begin
      level_o   = sdac_pkg::LVL_INVALID;
      fault_o   = sdac_pkg::FLT_TYPE;
    end else if (not_finite_i) begin
      level_o   = sdac_pkg::LVL_INVALID;
      fault_o   = sdac_pkg::FLT_BAD_NUM;
    end else begin
      quality_o = 1'b1;
      if (!drop) begin
        fault_o      = sdac_pkg::FLT_NONE;
        held_value_o = sample_i;
        held_valid_o = 1'b1;
        taken_o      = 1'b1;
        if (ctrl_i.strict_policy) begin
          level_o = class_lvl;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/sensor_deadband_alarm_classifier_core_tb.sv
// Self-checking testbench for the sensor deadband alarm classifier core.
`timescale 1ns / 100ps

// Test flow:
//   - one reset at the start, then directed tests for reset defaults, register
//     access, fault priority, deadband filtering, level hysteresis and the
//     non-strict policy
//   - random traffic in four idling phases (none, sender gaps, receiver stalls,
//     both), each phase run under three register settings
//   - every accepted sample request is run through the local classifier model;
//     the monitor compares each accepted result request with the oldest
//     prediction, field by field
//   - a watchdog ends the run if no request moves for too long
module sensor_deadband_alarm_classifier_core_tb;

  localparam int VW          = sdac_pkg::VALUE_WIDTH_DEF;
  localparam int AW          = sdac_pkg::paddr_w(VW);
  localparam int DW          = sdac_pkg::pdata_w(VW);
  localparam int ONE         = 65536;     // 1.0 in Q16.16
  localparam int STALL_LIMIT = 4000;      // cycles with no request moving
  localparam int SEG_ITEMS   = 130;       // random samples per register setting
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    sdac_pkg::level_e level;
    sdac_pkg::fault_e fault;
    logic             quality;
    logic [VW-1:0]    held;
    logic             held_vld;
    logic             taken;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  // APB side
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  sdac_smp_if #(.VALUE_WIDTH(VW)) smp_if ();
  sdac_res_if #(.VALUE_WIDTH(VW)) res_if ();

  sensor_deadband_alarm_classifier_core #(.VALUE_WIDTH(VW)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .smp_i   (smp_if.sink),
    .res_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted results, oldest first
  verdict_t verdict_q[$];

  // Local copy of the classifier state
  logic [VW-1:0]    st_value;
  logic             st_valid;
  sdac_pkg::level_e st_level;
  sdac_pkg::fault_e st_fault;
  logic             st_quality;

  // Local copy of the register file
  logic [VW-2:0] c_deadband;
  logic [VW-1:0] c_warn_lo;
  logic [VW-1:0] c_warn_hi;
  logic [VW-1:0] c_alm_lo;
  logic [VW-1:0] c_alm_hi;
  logic [6:0]    c_hyst_pct;
  logic          c_strict;
  logic          c_analog;

  // Idling knobs, percent of cycles, and the spread of random samples
  int gap_pct;
  int stall_pct;
  int sample_spread;

  int err_count;
  int reports;
  int samples_sent;
  int results_checked;
  int taken_count;
  int configs_applied;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Classifier model
  // ---------------------------------------------------------------------------

  // offset binary: unsigned order equals signed order
  function automatic logic [63:0] offset_bin(input logic [VW-1:0] x);
    return {{(64-VW){1'b0}}, x ^ (VW'(1) << (VW-1))};
  endfunction

  function automatic sdac_pkg::level_e classify_level(input logic [VW-1:0] raw,
                                                      input sdac_pkg::level_e prev);
    logic [63:0] v, wl, wh, al, ah, span, pct, band;
    logic        in_alarm, in_warn;
    v  = offset_bin(raw);
    wl = offset_bin(c_warn_lo);
    wh = offset_bin(c_warn_hi);
    al = offset_bin(c_alm_lo);
    ah = offset_bin(c_alm_hi);
    span = (wh >= wl) ? wh - wl : wl - wh;
    pct  = (c_hyst_pct > sdac_pkg::PCT_MAX) ? 64'(sdac_pkg::PCT_MAX) : 64'(c_hyst_pct);
    band = (span / 100) * pct + ((span % 100) * pct) / 100;
    in_alarm = (v <= al) || (v >= ah);
    in_warn  = (v <= wl) || (v >= wh);
    if (in_alarm) return sdac_pkg::LVL_ALARM;
    if (prev == sdac_pkg::LVL_ALARM) begin
      // alarm holds until the value is clear of both alarm limits by the band
      if (!(ah > v && ah - v > band) || !(v > al && v - al > band)) return sdac_pkg::LVL_ALARM;
      return in_warn ? sdac_pkg::LVL_WARN : sdac_pkg::LVL_OK;
    end
    if (prev == sdac_pkg::LVL_WARN) begin
      if ((v > wl && v - wl > band) && (wh > v && wh - v > band)) return sdac_pkg::LVL_OK;
      return sdac_pkg::LVL_WARN;
    end
    return in_warn ? sdac_pkg::LVL_WARN : sdac_pkg::LVL_OK;
  endfunction

  task automatic predict_sample(input logic [VW-1:0] s, input logic q_ok, input logic not_fin);
    verdict_t    v;
    logic [63:0] a, b, gap_abs;
    v.taken = 1'b0;
    if (!q_ok) begin
      st_quality = 1'b0;
      st_level   = sdac_pkg::LVL_INVALID;
      st_fault   = sdac_pkg::FLT_QUALITY;
    end else if (!c_analog) begin
      st_level = sdac_pkg::LVL_INVALID;
      st_fault = sdac_pkg::FLT_TYPE;
    end else if (not_fin) begin
      st_level = sdac_pkg::LVL_INVALID;
      st_fault = sdac_pkg::FLT_BAD_NUM;
    end else begin
      st_quality = 1'b1;
      a = offset_bin(s);
      b = offset_bin(st_value);
      gap_abs = (a >= b) ? a - b : b - a;
      // inside the deadband: dropped, level and fault kept
      if (!(st_valid && c_deadband != '0 && gap_abs < 64'(c_deadband))) begin
        st_fault = sdac_pkg::FLT_NONE;
        if (c_strict) st_level = classify_level(s, st_level);
        st_value = s;
        st_valid = 1'b1;
        v.taken  = 1'b1;
        taken_count++;
      end
    end
    v.level    = st_level;
    v.fault    = st_fault;
    v.quality  = st_quality;
    v.held     = st_value;
    v.held_vld = st_valid;
    verdict_q.push_back(v);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // register write, then read back and compare with the masked value
  task automatic write_reg(input sdac_pkg::reg_idx_e idx, input logic [VW-1:0] val);
    logic [DW-1:0] stored;
    logic [DW-1:0] got;
    case (idx)
      sdac_pkg::REG_DEADBAND: begin
        c_deadband = val[VW-2:0]; stored = DW'(c_deadband);
      end
      sdac_pkg::REG_WARN_LOW:   begin c_warn_lo  = val;      stored = DW'(val);        end
      sdac_pkg::REG_WARN_HIGH:  begin c_warn_hi  = val;      stored = DW'(val);        end
      sdac_pkg::REG_ALARM_LOW:  begin c_alm_lo   = val;      stored = DW'(val);        end
      sdac_pkg::REG_ALARM_HIGH: begin c_alm_hi   = val;      stored = DW'(val);        end
      sdac_pkg::REG_HYST_PCT:   begin c_hyst_pct = val[6:0]; stored = DW'(c_hyst_pct); end
      sdac_pkg::REG_STRICT:     begin c_strict   = val[0];   stored = DW'(c_strict);   end
      default:                  begin c_analog   = val[0];   stored = DW'(c_analog);   end
    endcase
    // write: setup then access
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, {sdac_pkg::pstride_log(VW){1'b0}}});
    pwdata  <= DW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read back
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== stored) begin
      err_count++;
      $display("%0t: register %s readback: expected %h, actual %h", $realtime, idx.name(),
               stored, got);
    end
  endtask

  task automatic apply_config(input logic [VW-1:0] db, input logic [VW-1:0] wl,
                              input logic [VW-1:0] wh, input logic [VW-1:0] al,
                              input logic [VW-1:0] ah, input logic [6:0] pct,
                              input logic strict, input logic analog);
    write_reg(sdac_pkg::REG_DEADBAND, db);
    write_reg(sdac_pkg::REG_WARN_LOW, wl);
    write_reg(sdac_pkg::REG_WARN_HIGH, wh);
    write_reg(sdac_pkg::REG_ALARM_LOW, al);
    write_reg(sdac_pkg::REG_ALARM_HIGH, ah);
    write_reg(sdac_pkg::REG_HYST_PCT, VW'(pct));
    write_reg(sdac_pkg::REG_STRICT, VW'(strict));
    write_reg(sdac_pkg::REG_ANALOG, VW'(analog));
    configs_applied++;
    // hysteresis product settles in the cycle after the last write
    repeat (3) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sample channel
  // ---------------------------------------------------------------------------

  // one sample request; valid stays high afterwards so requests can run back to back
  task automatic send_sample(input logic [VW-1:0] s, input logic q_ok, input logic not_fin);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      smp_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    smp_if.valid             <= 1'b1;
    smp_if.sample            <= s;
    smp_if.sample_quality_ok <= q_ok;
    smp_if.sample_not_finite <= not_fin;
    do @(posedge clk_i); while (!smp_if.ready);
    samples_sent++;
    predict_sample(s, q_ok, not_fin);
  endtask

  // stop sending and wait until every prediction has been matched
  task automatic drain_pipeline();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly near the limits or the held value so every level and deadband edge is hit
  function automatic logic [VW-1:0] pick_sample();
    int            sel;
    int            off;
    logic [VW-1:0] base;
    sel = $urandom_range(9);
    if (sel < 3) return VW'($urandom);
    case ($urandom_range(3))
      0:       base = c_warn_lo;
      1:       base = c_warn_hi;
      2:       base = c_alm_lo;
      default: base = c_alm_hi;
    endcase
    if (sel == 7) base = st_value;
    if (sel == 8) begin
      // just around the deadband edge from the held value
      off = int'(c_deadband) + int'($urandom_range(2)) - 1;
      if ($urandom_range(1)) off = -off;
      return st_value + VW'(off);
    end
    if (sel == 9) off = int'($urandom_range(4)) - 2;
    else off = int'($urandom_range(2 * sample_spread)) - sample_spread;
    return base + VW'(off);
  endfunction

  // ---------------------------------------------------------------------------
  // Result monitor and watchdog
  // ---------------------------------------------------------------------------

  task automatic report(input string field, input logic [VW-1:0] want, input logic [VW-1:0] got);
    err_count++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_result
    verdict_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        err_count++;
        $display("%0t: result request with no prediction pending", $realtime);
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        if (res_if.level_status !== want.level)
          report("level_status", VW'(want.level), VW'(res_if.level_status));
        if (res_if.fault_code !== want.fault)
          report("fault_code", VW'(want.fault), VW'(res_if.fault_code));
        if (res_if.quality_flag !== want.quality)
          report("quality_flag", VW'(want.quality), VW'(res_if.quality_flag));
        if (res_if.held_value !== want.held)
          report("held_value", want.held, res_if.held_value);
        if (res_if.held_valid !== want.held_vld)
          report("held_valid", VW'(want.held_vld), VW'(res_if.held_valid));
        if (res_if.sample_taken !== want.taken)
          report("sample_taken", VW'(want.taken), VW'(res_if.sample_taken));
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("sensor_deadband_alarm_classifier_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset config: all limits zero, strict on, analog on
  task automatic test_reset_defaults();
    send_sample(VW'(ONE), 1'b1, 1'b0);
    send_sample(VW'(ONE), 1'b1, 1'b0);
    drain_pipeline();
  endtask

  // every register at its extremes, then a working setting
  task automatic test_register_access();
    apply_config({1'b0, {(VW-1){1'b1}}}, {1'b1, {(VW-1){1'b0}}}, {1'b0, {(VW-1){1'b1}}},
                 {1'b1, {(VW-1){1'b0}}}, {1'b0, {(VW-1){1'b1}}}, 7'h7f, 1'b0, 1'b0);
    apply_config('0, VW'(-10 * ONE), VW'(10 * ONE), VW'(-20 * ONE), VW'(20 * ONE),
                 7'd0, 1'b1, 1'b1);
  endtask

  // quality first, then device type, then number
  task automatic test_fault_priority();
    send_sample(VW'(5 * ONE), 1'b0, 1'b1);
    send_sample(VW'(5 * ONE), 1'b1, 1'b1);
    send_sample(VW'(5 * ONE), 1'b1, 1'b0);
    drain_pipeline();
    write_reg(sdac_pkg::REG_ANALOG, VW'(0));
    repeat (2) @(negedge clk_i);
    send_sample(VW'(6 * ONE), 1'b1, 1'b1);
    send_sample(VW'(6 * ONE), 1'b0, 1'b0);
    drain_pipeline();
    write_reg(sdac_pkg::REG_ANALOG, VW'(1));
    repeat (2) @(negedge clk_i);
    send_sample(VW'(6 * ONE), 1'b1, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_deadband_filter();
    write_reg(sdac_pkg::REG_DEADBAND, VW'(ONE));
    repeat (2) @(negedge clk_i);
    send_sample(VW'(0), 1'b1, 1'b0);
    send_sample(VW'(ONE), 1'b1, 1'b0);        // exactly one band away: taken
    send_sample(VW'(1), 1'b1, 1'b0);          // just inside: dropped
    drain_pipeline();
    write_reg(sdac_pkg::REG_DEADBAND, {1'b0, {(VW-1){1'b1}}});
    repeat (2) @(negedge clk_i);
    send_sample({1'b1, {(VW-1){1'b0}}}, 1'b1, 1'b0);
    send_sample({1'b0, {(VW-1){1'b1}}}, 1'b1, 1'b0);
    send_sample(VW'(0), 1'b1, 1'b0);
    drain_pipeline();
    write_reg(sdac_pkg::REG_DEADBAND, VW'(0));
    repeat (2) @(negedge clk_i);
  endtask

  // warn at +-10, alarm at +-20, band 10 percent of 20 = 2.0
  task automatic test_level_hysteresis();
    write_reg(sdac_pkg::REG_HYST_PCT, VW'(10));
    repeat (2) @(negedge clk_i);
    send_sample(VW'(0), 1'b1, 1'b0);
    send_sample(VW'(10 * ONE), 1'b1, 1'b0);
    send_sample(VW'(9 * ONE), 1'b1, 1'b0);    // held in warning
    send_sample(VW'(7 * ONE), 1'b1, 1'b0);    // clear of the band: ok
    send_sample(VW'(20 * ONE), 1'b1, 1'b0);
    send_sample(VW'(19 * ONE), 1'b1, 1'b0);   // held in alarm
    send_sample(VW'(17 * ONE), 1'b1, 1'b0);   // back to warning
    send_sample(VW'(-21 * ONE), 1'b1, 1'b0);
    send_sample(VW'(0), 1'b1, 1'b0);
    drain_pipeline();
    // percent above the maximum clamps
    write_reg(sdac_pkg::REG_HYST_PCT, VW'(127));
    repeat (2) @(negedge clk_i);
    send_sample(VW'(5 * ONE), 1'b1, 1'b0);
    drain_pipeline();
  endtask

  // policy off: an accepted value leaves the level alone, invalid included
  task automatic test_policy_off();
    write_reg(sdac_pkg::REG_STRICT, VW'(0));
    repeat (2) @(negedge clk_i);
    send_sample(VW'(3 * ONE), 1'b0, 1'b0);
    send_sample(VW'(3 * ONE), 1'b1, 1'b0);
    drain_pipeline();
  endtask

  // variant 0: ordered limits; 1: full-scale alarm limits; 2: anything goes
  task automatic random_config(input int variant);
    int            ctr, s1, s2, s3, s4;
    logic [VW-1:0] wl, wh, al, ah, tmp, db;
    logic [6:0]    pct;
    logic          strict, analog;
    ctr = int'($urandom_range(32'h2000_0000)) - 32'h1000_0000;
    s1  = int'($urandom_range(1 << 24, 1));
    s2  = int'($urandom_range(1 << 24, 1));
    s3  = int'($urandom_range(1 << 24, 1));
    s4  = int'($urandom_range(1 << 24, 1));
    wl  = VW'(ctr - s1);
    wh  = VW'(ctr + s2);
    al  = VW'(ctr - s1 - s3);
    ah  = VW'(ctr + s2 + s4);
    sample_spread = (s1 + s2 + s3 + s4) / 2 + 16;
    db     = ($urandom_range(2) == 0) ? '0 : VW'($urandom_range(s1 / 4 + 1, 1));
    pct    = 7'($urandom_range(127));
    strict = 1'b1;
    analog = 1'b1;
    if (variant == 1) begin
      al  = {1'b1, {(VW-1){1'b0}}};
      ah  = {1'b0, {(VW-1){1'b1}}};
      pct = sdac_pkg::PCT_MAX;
      db  = '0;
    end else if (variant == 2) begin
      if ($urandom_range(1)) begin tmp = wl; wl = wh; wh = tmp; end
      if ($urandom_range(1)) begin tmp = al; al = ah; ah = tmp; end
      db     = ($urandom_range(3) == 0) ? {1'b0, {(VW-1){1'b1}}} : VW'($urandom_range(s1));
      strict = 1'($urandom_range(1));
      analog = ($urandom_range(7) != 0);
    end
    apply_config(db, wl, wh, al, ah, pct, strict, analog);
  endtask

  task automatic test_random_traffic();
    int gaps[4];
    int stalls[4];
    gaps   = '{0, 56, 0, 14};
    stalls = '{0, 0, 56, 14};
    for (int ph = 0; ph < 4; ph++) begin
      for (int variant = 0; variant < 3; variant++) begin
        gap_pct   = 0;
        stall_pct = 0;
        random_config(variant);
        gap_pct   = gaps[ph];
        stall_pct = stalls[ph];
        for (int n = 0; n < SEG_ITEMS; n++)
          send_sample(pick_sample(), ($urandom_range(15) != 0), ($urandom_range(19) == 0));
        drain_pipeline();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni                   = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    smp_if.valid             = 1'b0;
    smp_if.sample            = '0;
    smp_if.sample_quality_ok = 1'b0;
    smp_if.sample_not_finite = 1'b0;
    res_if.ready             = 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    sample_spread   = 16;
    err_count       = 0;
    reports         = 0;
    samples_sent    = 0;
    results_checked = 0;
    taken_count     = 0;
    configs_applied = 0;
    idle_cycles     = 0;
    // model state and registers at their reset values
    st_value   = '0;
    st_valid   = 1'b0;
    st_level   = sdac_pkg::LVL_OK;
    st_fault   = sdac_pkg::FLT_NONE;
    st_quality = 1'b1;
    c_deadband = '0;
    c_warn_lo  = '0;
    c_warn_hi  = '0;
    c_alm_lo   = '0;
    c_alm_hi   = '0;
    c_hyst_pct = '0;
    c_strict   = 1'b1;
    c_analog   = 1'b1;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_access();
    test_fault_priority();
    test_deadband_filter();
    test_level_hysteresis();
    test_policy_off();
    test_random_traffic();

    drain_pipeline();
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d predicted results never arrived", $realtime, verdict_q.size());
    end

    $display("Covered %0d sample requests (%0d taken) under %0d register settings,",
             samples_sent, taken_count, configs_applied);
    $display("four idling phases, %0d results checked, %0d errors.", results_checked,
             err_count);
    if (err_count == 0) begin
      $display("sensor_deadband_alarm_classifier_core test passed");
    end else begin
      $display("sensor_deadband_alarm_classifier_core test failed");
    end
    $finish;
  end

endmodule
